FILE: hdl/blr_pkg.sv
// shared types and constants of the bilinear layer resampler
package blr_pkg;

    localparam int DEF_MAX_SOURCE_WIDTH  = 256;
    localparam int DEF_MAX_SOURCE_HEIGHT = 256;
    localparam int DEF_FRACTION_BITS     = 8;

    localparam int ADDR_W       = 16;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int PIXEL_W      = 32;
    localparam int COORD_W      = 15;
    localparam int RECT_W       = 16;
    localparam int SIZE_W       = 9;
    localparam int SCALE_W      = 25;
    localparam int SCALE_SHIFT  = 16;
    localparam int DELTA_W      = 16;
    localparam int PROD_W       = DELTA_W + SCALE_W;
    localparam int CHAN_BITS    = 8;
    localparam int CHAN_MAX     = 255;
    localparam int NUM_CHAN     = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 25;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_RECT_LEFT     = 3'd2,
        CFG_RECT_TOP      = 3'd3,
        CFG_RECT_RIGHT    = 3'd4,
        CFG_RECT_BOTTOM   = 3'd5,
        CFG_SCALE_X       = 3'd6,
        CFG_SCALE_Y       = 3'd7
    } cfg_index_t;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_RENDER = 1'b1
    } mode_t;

    typedef struct packed {
        logic                mode;
        logic [ADDR_W-1:0]   source_address;
        logic [PIXEL_W-1:0]  source_pixel;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
    } in_item_t;

    typedef struct packed {
        logic                inside_res;
        logic [PIXEL_W-1:0]  cmyk_pixel;
    } out_item_t;

endpackage

FILE: hdl/bilinear_layer_resampler.sv
// bilinear layer resampler: source store and eight-stage interpolation pipeline
//
// s_ channel takes items: mode 0 loads source_pixel into the store at
// source_address, mode 1 renders point (out_x, out_y). m_ channel gives one
// result per item, in order: inside_res and cmyk_pixel, both zero for a load
// or for a point outside the clipped layer rectangle.
// cfg_write with cfg_index and cfg_data sets a register; write
// only while no item is in flight.
// one item per cycle is sustained while results are taken; the multipliers
// of the mapping, row base and two lerp steps each own a stage, and the
// store is kept as two copies with two read ports each so all four
// neighbours are read in the same cycle.
// loads write the store in the same stage where renders read it, so a
// render always sees every earlier load.
// when m_ready is low with a result waiting the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// aresetn clears the valid bits and the registers to their reset values; the
// store is not cleared and must be loaded before it is read.
module bilinear_layer_resampler
    import blr_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
    parameter int FRACTION_BITS     = DEF_FRACTION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    localparam int F    = FRACTION_BITS;
    localparam int IXW  = $clog2(MAX_SOURCE_WIDTH);
    localparam int IYW  = $clog2(MAX_SOURCE_HEIGHT);
    localparam int WW   = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int HW   = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int MW   = (IYW + WW > ADDR_W) ? IYW + WW : ADDR_W;
    localparam int IP_W = PROD_W - SCALE_SHIFT;
    localparam int TW   = CHAN_BITS + F + 2;
    localparam int PW   = CHAN_BITS + 2 * F + 2;
    localparam int SC_W = COORD_W + 2;

    localparam logic signed [PW-1:0] CLAMP_HI = PW'(CHAN_MAX);

    // configuration registers
    logic [SIZE_W-1:0]         source_width_reg;
    logic [SIZE_W-1:0]         source_height_reg;
    logic signed [RECT_W-1:0]  rect_left_reg;
    logic signed [RECT_W-1:0]  rect_top_reg;
    logic signed [RECT_W-1:0]  rect_right_reg;
    logic signed [RECT_W-1:0]  rect_bottom_reg;
    logic [SCALE_W-1:0]        scale_x_reg;
    logic [SCALE_W-1:0]        scale_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= SIZE_RESET;
            source_height_reg <= SIZE_RESET;
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_right_reg    <= '0;
            rect_bottom_reg   <= '0;
            scale_x_reg       <= SCALE_RESET;
            scale_y_reg       <= SCALE_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_RECT_LEFT:     rect_left_reg     <= cfg_data[RECT_W-1:0];
                CFG_RECT_TOP:      rect_top_reg      <= cfg_data[RECT_W-1:0];
                CFG_RECT_RIGHT:    rect_right_reg    <= cfg_data[RECT_W-1:0];
                CFG_RECT_BOTTOM:   rect_bottom_reg   <= cfg_data[RECT_W-1:0];
                CFG_SCALE_X:       scale_x_reg       <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:       scale_y_reg       <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective source size
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [IXW-1:0] w_last;
    logic [IYW-1:0] h_last;

    always_comb begin
        if (source_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (int'(source_width_reg) > MAX_SOURCE_WIDTH) begin
            w_eff = WW'(MAX_SOURCE_WIDTH);
        end else begin
            w_eff = WW'(source_width_reg);
        end
        if (source_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (int'(source_height_reg) > MAX_SOURCE_HEIGHT) begin
            h_eff = HW'(MAX_SOURCE_HEIGHT);
        end else begin
            h_eff = HW'(source_height_reg);
        end
        w_last = IXW'(w_eff - WW'(1));
        h_last = IYW'(h_eff - HW'(1));
    end

    // pipeline advance
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic adv;

    assign adv     = !v8_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // stage 1: rectangle test and offsets
    logic signed [SC_W-1:0] px, py, x0, y0, left_s, top_s, right_s, bottom_s;
    logic signed [SC_W-1:0] dx_full, dy_full;
    logic                   hit_next;

    always_comb begin
        px       = $signed({2'b00, s_data.out_x});
        py       = $signed({2'b00, s_data.out_y});
        left_s   = SC_W'(rect_left_reg);
        top_s    = SC_W'(rect_top_reg);
        right_s  = SC_W'(rect_right_reg);
        bottom_s = SC_W'(rect_bottom_reg);
        x0       = (left_s > 0) ? left_s : '0;
        y0       = (top_s > 0) ? top_s : '0;
        hit_next = (s_data.mode == MODE_RENDER) && (px >= x0) && (px < right_s)
                   && (py >= y0) && (py < bottom_s);
        dx_full  = px - left_s;
        dy_full  = py - top_s;
    end

    logic                 s1_load_reg, s1_hit_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [PIXEL_W-1:0]   s1_pixel_reg;
    logic [DELTA_W-1:0]   s1_dx_reg, s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_load_reg  <= (s_data.mode == MODE_LOAD);
            s1_hit_reg   <= hit_next;
            s1_addr_reg  <= s_data.source_address;
            s1_pixel_reg <= s_data.source_pixel;
            s1_dx_reg    <= dx_full[DELTA_W-1:0];
            s1_dy_reg    <= dy_full[DELTA_W-1:0];
        end
    end

    // stage 2: scale multiply
    logic                 s2_load_reg, s2_hit_reg;
    logic [ADDR_W-1:0]    s2_addr_reg;
    logic [PIXEL_W-1:0]   s2_pixel_reg;
    logic [PROD_W-1:0]    s2_sx_reg, s2_sy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_load_reg  <= s1_load_reg;
            s2_hit_reg   <= s1_hit_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_pixel_reg <= s1_pixel_reg;
            s2_sx_reg    <= PROD_W'(s1_dx_reg) * PROD_W'(scale_x_reg);
            s2_sy_reg    <= PROD_W'(s1_dy_reg) * PROD_W'(scale_y_reg);
        end
    end

    // stage 3: neighbour index clamp
    logic [IP_W-1:0] ipx, ipy;
    logic [IXW-1:0]  ix0_next, ix1_next;
    logic [IYW-1:0]  iy0_next, iy1_next;

    always_comb begin
        ipx      = s2_sx_reg[PROD_W-1:SCALE_SHIFT];
        ipy      = s2_sy_reg[PROD_W-1:SCALE_SHIFT];
        ix0_next = (ipx > IP_W'(w_last)) ? w_last : ipx[IXW-1:0];
        ix1_next = (ipx >= IP_W'(w_last)) ? w_last : ipx[IXW-1:0] + IXW'(1);
        iy0_next = (ipy > IP_W'(h_last)) ? h_last : ipy[IYW-1:0];
        iy1_next = (ipy >= IP_W'(h_last)) ? h_last : ipy[IYW-1:0] + IYW'(1);
    end

    logic                 s3_load_reg, s3_hit_reg;
    logic [ADDR_W-1:0]    s3_addr_reg;
    logic [PIXEL_W-1:0]   s3_pixel_reg;
    logic [IXW-1:0]       s3_ix0_reg, s3_ix1_reg;
    logic [IYW-1:0]       s3_iy0_reg, s3_iy1_reg;
    logic [F-1:0]         s3_fx_reg, s3_fy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_load_reg  <= s2_load_reg;
            s3_hit_reg   <= s2_hit_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_pixel_reg <= s2_pixel_reg;
            s3_ix0_reg   <= ix0_next;
            s3_ix1_reg   <= ix1_next;
            s3_iy0_reg   <= iy0_next;
            s3_iy1_reg   <= iy1_next;
            s3_fx_reg    <= s2_sx_reg[SCALE_SHIFT-1 -: F];
            s3_fy_reg    <= s2_sy_reg[SCALE_SHIFT-1 -: F];
        end
    end

    // stage 4: store addresses
    logic [MW-1:0] base0, base1;
    logic [MW-1:0] a00_full, a10_full, a01_full, a11_full;

    always_comb begin
        base0    = MW'(s3_iy0_reg) * MW'(w_eff);
        base1    = MW'(s3_iy1_reg) * MW'(w_eff);
        a00_full = base0 + MW'(s3_ix0_reg);
        a10_full = base0 + MW'(s3_ix1_reg);
        a01_full = base1 + MW'(s3_ix0_reg);
        a11_full = base1 + MW'(s3_ix1_reg);
    end

    logic                 s4_load_reg, s4_hit_reg;
    logic [PIXEL_W-1:0]   s4_pixel_reg;
    logic [ADDR_W-1:0]    s4_a00_reg, s4_a10_reg, s4_a01_reg, s4_a11_reg;
    logic [F-1:0]         s4_fx_reg, s4_fy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_load_reg  <= s3_load_reg;
            s4_hit_reg   <= s3_hit_reg;
            s4_pixel_reg <= s3_pixel_reg;
            s4_a00_reg   <= s3_load_reg ? s3_addr_reg : a00_full[ADDR_W-1:0];
            s4_a10_reg   <= a10_full[ADDR_W-1:0];
            s4_a01_reg   <= a01_full[ADDR_W-1:0];
            s4_a11_reg   <= a11_full[ADDR_W-1:0];
            s4_fx_reg    <= s3_fx_reg;
            s4_fy_reg    <= s3_fy_reg;
        end
    end

    // stage 5: source store, two copies with two read ports each
    logic [PIXEL_W-1:0] store_top [STORE_DEPTH];
    logic [PIXEL_W-1:0] store_bot [STORE_DEPTH];

    logic               s5_hit_reg;
    logic [PIXEL_W-1:0] s5_q00_reg, s5_q10_reg, s5_q01_reg, s5_q11_reg;
    logic [F-1:0]       s5_fx_reg, s5_fy_reg;

    always_ff @(posedge aclk) begin
        if (adv && v4_reg && s4_load_reg) begin
            store_top[s4_a00_reg] <= s4_pixel_reg;
        end
        if (adv) begin
            s5_q00_reg <= store_top[s4_a00_reg];
            s5_q10_reg <= store_top[s4_a10_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v4_reg && s4_load_reg) begin
            store_bot[s4_a00_reg] <= s4_pixel_reg;
        end
        if (adv) begin
            s5_q01_reg <= store_bot[s4_a01_reg];
            s5_q11_reg <= store_bot[s4_a11_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_hit_reg <= s4_hit_reg;
            s5_fx_reg  <= s4_fx_reg;
            s5_fy_reg  <= s4_fy_reg;
        end
    end

    // stage 6: horizontal lerp
    logic signed [TW-1:0] top_next [NUM_CHAN];
    logic signed [TW-1:0] bot_next [NUM_CHAN];
    logic signed [TW-1:0] fx_ext;

    always_comb begin
        logic [CHAN_BITS-1:0] p00, p10, p01, p11;
        logic signed [TW-1:0] d_top, d_bot;
        fx_ext = TW'($signed({1'b0, s5_fx_reg}));
        for (int c = 0; c < NUM_CHAN; c++) begin
            p00         = s5_q00_reg[c*CHAN_BITS +: CHAN_BITS];
            p10         = s5_q10_reg[c*CHAN_BITS +: CHAN_BITS];
            p01         = s5_q01_reg[c*CHAN_BITS +: CHAN_BITS];
            p11         = s5_q11_reg[c*CHAN_BITS +: CHAN_BITS];
            d_top       = TW'($signed({1'b0, p10})) - TW'($signed({1'b0, p00}));
            d_bot       = TW'($signed({1'b0, p11})) - TW'($signed({1'b0, p01}));
            top_next[c] = (TW'($signed({1'b0, p00})) <<< F) + d_top * fx_ext;
            bot_next[c] = (TW'($signed({1'b0, p01})) <<< F) + d_bot * fx_ext;
        end
    end

    logic                 s6_hit_reg;
    logic [F-1:0]         s6_fy_reg;
    logic signed [TW-1:0] s6_top_reg [NUM_CHAN];
    logic signed [TW-1:0] s6_bot_reg [NUM_CHAN];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_hit_reg <= s5_hit_reg;
            s6_fy_reg  <= s5_fy_reg;
            s6_top_reg <= top_next;
            s6_bot_reg <= bot_next;
        end
    end

    // stage 7: vertical weight multiply
    logic signed [PW-1:0] vprod_next [NUM_CHAN];
    logic signed [PW-1:0] fy_ext;

    always_comb begin
        fy_ext = PW'($signed({1'b0, s6_fy_reg}));
        for (int c = 0; c < NUM_CHAN; c++) begin
            vprod_next[c] = PW'(s6_bot_reg[c] - s6_top_reg[c]) * fy_ext;
        end
    end

    logic                 s7_hit_reg;
    logic signed [TW-1:0] s7_top_reg   [NUM_CHAN];
    logic signed [PW-1:0] s7_vprod_reg [NUM_CHAN];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_hit_reg   <= s6_hit_reg;
            s7_top_reg   <= s6_top_reg;
            s7_vprod_reg <= vprod_next;
        end
    end

    // output register: sum, round down and clamp
    out_item_t out_next;
    out_item_t out_reg;

    always_comb begin
        logic signed [PW-1:0] val, v8;
        out_next = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            val = PW'(s7_top_reg[c]) + (s7_vprod_reg[c] >>> F);
            v8  = val >>> F;
            if (v8 < 0) begin
                out_next.cmyk_pixel[c*CHAN_BITS +: CHAN_BITS] = '0;
            end else if (v8 > CLAMP_HI) begin
                out_next.cmyk_pixel[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(CHAN_MAX);
            end else begin
                out_next.cmyk_pixel[c*CHAN_BITS +: CHAN_BITS] = v8[CHAN_BITS-1:0];
            end
        end
        if (!s7_hit_reg) begin
            out_next.cmyk_pixel = '0;
        end
        out_next.inside_res = s7_hit_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: tb/resampled_pixel_checker.sv
// checker for the bilinear layer resampler: predicts every result and compares in order
module resampled_pixel_checker
    import blr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    output int                     pixels_in_flight,
    output int                     mismatch_count
);
    localparam int FRAC = DEF_FRACTION_BITS;

    logic [PIXEL_W-1:0]       layer_copy [STORE_DEPTH];
    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic signed [RECT_W-1:0] left_reg;
    logic signed [RECT_W-1:0] top_reg;
    logic signed [RECT_W-1:0] right_reg;
    logic signed [RECT_W-1:0] bottom_reg;
    logic [SCALE_W-1:0]       scale_x_reg;
    logic [SCALE_W-1:0]       scale_y_reg;
    out_item_t                awaited_pixels [$];
    int                       errors = 0;

    function automatic int unsigned usable_size(input logic [SIZE_W-1:0] v,
                                                input int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic void map_axis(input int unsigned d, input logic [SCALE_W-1:0] scale,
                                     input int unsigned size, output int unsigned i0,
                                     output int unsigned i1, output int frac);
        longint unsigned prod;
        longint unsigned whole;
        prod  = longint'(d) * longint'(scale);
        whole = prod >> SCALE_SHIFT;
        frac  = int'((prod >> (SCALE_SHIFT - FRAC)) & ((1 << FRAC) - 1));
        i0    = (whole > size - 1) ? size - 1 : int'(whole);
        i1    = (whole + 1 > size - 1) ? size - 1 : int'(whole + 1);
    endfunction

    function automatic out_item_t resample_point(input in_item_t it);
        out_item_t          res;
        int                 x;
        int                 y;
        int                 x_lo;
        int                 y_lo;
        int unsigned        w;
        int unsigned        h;
        int unsigned        ix0;
        int unsigned        ix1;
        int unsigned        iy0;
        int unsigned        iy1;
        int                 fx;
        int                 fy;
        logic [PIXEL_W-1:0] q00;
        logic [PIXEL_W-1:0] q10;
        logic [PIXEL_W-1:0] q01;
        logic [PIXEL_W-1:0] q11;
        longint             p00;
        longint             p10;
        longint             p01;
        longint             p11;
        longint             upper;
        longint             lower;
        longint             blend;
        longint             level;
        res = '0;
        if (it.mode == MODE_LOAD)
            return res;
        x    = int'(it.out_x);
        y    = int'(it.out_y);
        x_lo = (left_reg > 0) ? int'(left_reg) : 0;
        y_lo = (top_reg > 0) ? int'(top_reg) : 0;
        if (x < x_lo || x >= int'(right_reg) || y < y_lo || y >= int'(bottom_reg))
            return res;
        w = usable_size(width_reg, DEF_MAX_SOURCE_WIDTH);
        h = usable_size(height_reg, DEF_MAX_SOURCE_HEIGHT);
        map_axis(x - int'(left_reg), scale_x_reg, w, ix0, ix1, fx);
        map_axis(y - int'(top_reg), scale_y_reg, h, iy0, iy1, fy);
        q00 = layer_copy[ADDR_W'(iy0 * w + ix0)];
        q10 = layer_copy[ADDR_W'(iy0 * w + ix1)];
        q01 = layer_copy[ADDR_W'(iy1 * w + ix0)];
        q11 = layer_copy[ADDR_W'(iy1 * w + ix1)];
        for (int c = 0; c < NUM_CHAN; c++) begin
            p00   = longint'(q00[c*CHAN_BITS +: CHAN_BITS]);
            p10   = longint'(q10[c*CHAN_BITS +: CHAN_BITS]);
            p01   = longint'(q01[c*CHAN_BITS +: CHAN_BITS]);
            p11   = longint'(q11[c*CHAN_BITS +: CHAN_BITS]);
            upper = (p00 << FRAC) + (p10 - p00) * fx;
            lower = (p01 << FRAC) + (p11 - p01) * fx;
            blend = upper + (((lower - upper) * fy) >>> FRAC);
            level = blend >>> FRAC;
            if (level < 0)
                level = 0;
            if (level > CHAN_MAX)
                level = CHAN_MAX;
            res.cmyk_pixel[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(level);
        end
        res.inside_res = 1'b1;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            width_reg   = SIZE_RESET;
            height_reg  = SIZE_RESET;
            left_reg    = '0;
            top_reg     = '0;
            right_reg   = '0;
            bottom_reg  = '0;
            scale_x_reg = SCALE_RESET;
            scale_y_reg = SCALE_RESET;
            awaited_pixels.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  width_reg   = cfg_data[SIZE_W-1:0];
                    CFG_SOURCE_HEIGHT: height_reg  = cfg_data[SIZE_W-1:0];
                    CFG_RECT_LEFT:     left_reg    = cfg_data[RECT_W-1:0];
                    CFG_RECT_TOP:      top_reg     = cfg_data[RECT_W-1:0];
                    CFG_RECT_RIGHT:    right_reg   = cfg_data[RECT_W-1:0];
                    CFG_RECT_BOTTOM:   bottom_reg  = cfg_data[RECT_W-1:0];
                    CFG_SCALE_X:       scale_x_reg = cfg_data[SCALE_W-1:0];
                    CFG_SCALE_Y:       scale_y_reg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                awaited_pixels.insert(awaited_pixels.size(), resample_point(s_data));
                if (s_data.mode == MODE_LOAD)
                    layer_copy[s_data.source_address] = s_data.source_pixel;
            end
            if (m_valid && m_ready) begin
                if (awaited_pixels.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result with no item awaiting: inside %0b pixel %08h",
                                 m_data.inside_res, m_data.cmyk_pixel);
                end else begin
                    want = awaited_pixels.pop_front();
                    if (m_data.inside_res !== want.inside_res ||
                        m_data.cmyk_pixel !== want.cmyk_pixel) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected inside %0b pixel %08h, ",
                                      "got inside %0b pixel %08h"},
                                     want.inside_res, want.cmyk_pixel,
                                     m_data.inside_res, m_data.cmyk_pixel);
                    end
                end
            end
        end
        pixels_in_flight <= awaited_pixels.size();
        mismatch_count   <= errors;
    end

endmodule

FILE: tb/tb_bilinear_layer_resampler.sv
// testbench top for the bilinear layer resampler: stimulus, watchdog and verdict
module tb_bilinear_layer_resampler;
    import blr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 600;
    localparam int MAX_COORD    = (1 << COORD_W) - 1;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    int                     pixels_in_flight;
    int                     mismatch_count;

    int                     quiet_cycles = 0;
    int                     burst_left = 0;
    bit                     steady = 1'b0;
    int                     item_count = 0;
    int                     loaded_span = 0;
    int                     layer_span;
    int                     x_lo;
    int                     x_end;
    int                     y_lo;
    int                     y_end;
    logic [CFG_DATA_W-1:0]  layer_setting [8];
    int                     ready_pct [5] = '{100, 50, 85, 25, 0};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    bilinear_layer_resampler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    resampled_pixel_checker pixel_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .pixels_in_flight (pixels_in_flight),
        .mismatch_count   (mismatch_count)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int pct;
        int span;
        m_ready <= 1'b0;
        forever begin
            pct  = ready_pct[$urandom_range(0, 4)];
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(posedge aclk);
                m_ready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic int clamped_size(input int v, input int lim);
        if (v < 1)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t load_item(input int addr, input logic [PIXEL_W-1:0] pixel);
        in_item_t it;
        it.mode           = MODE_LOAD;
        it.source_address = ADDR_W'(addr);
        it.source_pixel   = pixel;
        it.out_x          = COORD_W'($urandom);
        it.out_y          = COORD_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t render_item(input int x, input int y);
        in_item_t it;
        it.mode           = MODE_RENDER;
        it.source_address = ADDR_W'($urandom);
        it.source_pixel   = $urandom;
        it.out_x          = COORD_W'(x);
        it.out_y          = COORD_W'(y);
        return it;
    endfunction

    function automatic int edge_coord(input int lo, input int hi);
        int c;
        c = $urandom_range(0, 1) ? lo : hi;
        c = c - int'($urandom_range(0, 1));
        if (c < 0)
            c = 0;
        if (c > MAX_COORD)
            c = MAX_COORD;
        return c;
    endfunction

    task automatic send_item(input in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        item_count++;
        if (!steady) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(0, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixels_in_flight != 0);
    endtask

    task automatic configure_layer(input int w, input int h, input int left, input int top,
                                   input int right, input int bottom, input int sx,
                                   input int sy);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        drain_results();
        layer_setting[CFG_SOURCE_WIDTH]  = CFG_DATA_W'(w);
        layer_setting[CFG_SOURCE_HEIGHT] = CFG_DATA_W'(h);
        layer_setting[CFG_RECT_LEFT]     = CFG_DATA_W'(RECT_W'(left));
        layer_setting[CFG_RECT_TOP]      = CFG_DATA_W'(RECT_W'(top));
        layer_setting[CFG_RECT_RIGHT]    = CFG_DATA_W'(RECT_W'(right));
        layer_setting[CFG_RECT_BOTTOM]   = CFG_DATA_W'(RECT_W'(bottom));
        layer_setting[CFG_SCALE_X]       = CFG_DATA_W'(sx);
        layer_setting[CFG_SCALE_Y]       = CFG_DATA_W'(sy);
        for (int i = 0; i < $size(layer_setting); i++) begin
            if (i < CFG_RECT_LEFT)
                keep = CFG_DATA_W'((1 << SIZE_W) - 1);
            else if (i < CFG_SCALE_X)
                keep = CFG_DATA_W'((1 << RECT_W) - 1);
            else
                keep = '1;
            junk = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
            cfg_write <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= (layer_setting[i] & keep) | (junk & ~keep);
            @(posedge aclk);
        end
        cfg_write  <= 1'b0;
        layer_span = clamped_size(w % (1 << SIZE_W), DEF_MAX_SOURCE_WIDTH) *
                     clamped_size(h % (1 << SIZE_W), DEF_MAX_SOURCE_HEIGHT);
        x_lo       = (left > 0) ? left : 0;
        y_lo       = (top > 0) ? top : 0;
        x_end      = right;
        y_end      = bottom;
        steady     = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_phase(input int w, input int h, input int left, input int top,
                             input int right, input int bottom, input int sx, input int sy,
                             input int count);
        int pick;
        configure_layer(w, h, left, top, right, bottom, sx, sy);
        for (int a = loaded_span; a < layer_span; a++)
            send_item(load_item(a, random_pixel()));
        if (layer_span > loaded_span)
            loaded_span = layer_span;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(load_item($urandom_range(0, layer_span - 1), random_pixel()));
            else if (pick < 16)
                send_item(load_item($urandom_range(0, STORE_DEPTH - 1), random_pixel()));
            else if (pick < 80 && x_lo < x_end && y_lo < y_end)
                send_item(render_item($urandom_range(x_lo, x_end - 1),
                                      $urandom_range(y_lo, y_end - 1)));
            else if (pick < 92)
                send_item(render_item(edge_coord(x_lo, x_end), edge_coord(y_lo, y_end)));
            else
                send_item(render_item($urandom_range(0, MAX_COORD),
                                      $urandom_range(0, MAX_COORD)));
        end
    endtask

    initial begin
        int first_random;
        int w;
        int h;
        int cw;
        int left;
        int top;
        int right;
        int bottom;
        int sx;
        int sy;
        aresetn   <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty rectangle after reset
        send_item(render_item(5, 5));

        configure_layer(2, 2, 0, 0, 4, 4, 'h8000, 'h8000);
        send_item(load_item(0, 32'h0000_0000));
        send_item(load_item(1, 32'hFFFF_FFFF));
        send_item(load_item(2, 32'h80FF_7F01));
        send_item(load_item(3, 32'h1234_5678));
        send_item(load_item(STORE_DEPTH - 1, 32'hA5A5_A5A5));
        loaded_span = 4;
        send_item(render_item(0, 0));
        send_item(render_item(1, 0));
        send_item(render_item(0, 1));
        send_item(render_item(1, 1));
        send_item(render_item(3, 3));
        send_item(render_item(4, 0));
        send_item(render_item(0, 4));
        send_item(render_item(MAX_COORD, MAX_COORD));

        // negative origin clipped to zero, zero and full scale
        configure_layer(2, 2, -2, -3, 2, 1, 0, 'h1FF_FFFF);
        send_item(render_item(0, 0));
        send_item(render_item(1, 0));
        send_item(render_item(2, 0));
        send_item(render_item(0, 1));

        first_random = item_count;
        run_phase(511, 0, -32768, -32768, 32767, 32767, 'h100, 'h1FF_FFFF, 60);
        run_phase(0, 511, 0, 0, 32767, 32767, 0, 'h200, 40);
        run_phase(256, 1, 100, 0, 50, 0, 'h1FF_FFFF, 'h1000000, 20);

        while (item_count - first_random < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: begin
                    w = $urandom_range(257, 511);
                    h = $urandom_range(0, 1);
                end
                1: begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(257, 511);
                end
                default: begin
                    w = $urandom_range(0, 16);
                    h = $urandom_range(0, 16);
                end
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    left  = int'($urandom_range(0, 400)) - 200;
                    top   = int'($urandom_range(0, 400)) - 200;
                    right = left - int'($urandom_range(0, 20));
                    bottom = top + int'($urandom_range(0, 40)) - 20;
                end
                1: begin
                    left   = int'($urandom_range(0, 65535)) - 32768;
                    top    = int'($urandom_range(0, 65535)) - 32768;
                    right  = left + int'($urandom_range(1, 1000));
                    bottom = top + int'($urandom_range(1, 1000));
                    if (right > 32767)
                        right = 32767;
                    if (bottom > 32767)
                        bottom = 32767;
                end
                default: begin
                    left   = int'($urandom_range(0, 400)) - 200;
                    top    = int'($urandom_range(0, 400)) - 200;
                    right  = left + int'($urandom_range(1, 80));
                    bottom = top + int'($urandom_range(1, 80));
                end
            endcase
            cw = clamped_size(w, DEF_MAX_SOURCE_WIDTH);
            sx = (cw << SCALE_SHIFT) / ((right - left) > 0 ? (right - left) : 1);
            sx = sx + int'($urandom_range(0, 64)) - 32;
            if (sx < 0)
                sx = 0;
            cw = clamped_size(h, DEF_MAX_SOURCE_HEIGHT);
            sy = (cw << SCALE_SHIFT) / ((bottom - top) > 0 ? (bottom - top) : 1);
            case ($urandom_range(0, 7))
                0: sx = $urandom_range(0, (1 << SCALE_W) - 1);
                1: sy = $urandom_range(0, (1 << SCALE_W) - 1);
                2: sx = 0;
                3: sy = $urandom_range(0, 'h20000);
                default: ;
            endcase
            run_phase(w, h, left, top, right, bottom, sx, sy, $urandom_range(15, 60));
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
